### design/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg: shared definitions for the set-associative tag lookup
// Default sizes, register indexes, request codes and the lookup result type.
// ----------------------------------------------------------------------------
package sactl_pkg;

	// Default sizing handed to the top level parameters.
	localparam int DEF_MAX_WAYS  = 8;
	localparam int DEF_MAX_SETS  = 1024;
	localparam int DEF_ADDR_BITS = 48;

	// Configuration port.
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_WAYS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETS_LOG  = 2'd2;

	localparam logic [CFG_W-1:0] RST_NUM_WAYS = 4'd4;
	localparam logic [CFG_W-1:0] RST_LINE_LOG = 4'd6;
	localparam logic [CFG_W-1:0] RST_SETS_LOG = 4'd10;

	// Request codes; anything else counts as neither a read nor a write.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;

	localparam int CNT_W   = 32;
	localparam int WAY_OUT = 3;
	localparam int RES_WAY = 4;

	// Outcome of one lookup, handed from the hit logic to the top level.
	typedef struct packed {
		logic               hit;
		logic [RES_WAY-1:0] way;
		logic               repl;
		logic               wb;
	} lkp_res_t;

endpackage

### design/sactl_tag_ram.sv
// ----------------------------------------------------------------------------
// sactl_tag_ram: tag store, one row per set
// Single write port and one registered read port. A read of the row being
// written in the same cycle returns the new row.
// ----------------------------------------------------------------------------
module sactl_tag_ram #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10,
	parameter int ROW_W = 400
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [ROW_W-1:0] wr_data
);

	logic [ROW_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with write-through forwarding on a same-row collision.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

### design/sactl_hit_logic.sv
// ----------------------------------------------------------------------------
// sactl_hit_logic: way compare and row update
// Compares the stored tags of one set, picks the lowest matching way, and
// builds the row to write back (dirty mark on a write hit, refill on a miss).
// ----------------------------------------------------------------------------
module sactl_hit_logic #(
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 48,
	parameter int WAY_W     = 3
) (
	input  logic [MAX_WAYS*(ADDR_BITS+2)-1:0] row_rd,
	input  logic [ADDR_BITS-1:0]              tag,
	input  logic [MAX_WAYS-1:0]               way_mask,
	input  logic [WAY_W-1:0]                  victim,
	input  logic                              is_write,
	output logic [MAX_WAYS*(ADDR_BITS+2)-1:0] row_wr,
	output sactl_pkg::lkp_res_t               res
);
	import sactl_pkg::*;

	localparam int ENTRY_W = ADDR_BITS + 2;
	localparam int V_BIT   = ENTRY_W - 1;
	localparam int D_BIT   = ENTRY_W - 2;

	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] valid;
	logic [MAX_WAYS-1:0] dirty;
	logic [WAY_W-1:0]    hit_way;
	logic                any_hit;

	// Per-way tag compare over the ways in use.
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			valid[w] = row_rd[w*ENTRY_W + V_BIT];
			dirty[w] = row_rd[w*ENTRY_W + D_BIT];
			match[w] = way_mask[w] && valid[w] &&
				(row_rd[w*ENTRY_W +: ADDR_BITS] == tag);
		end
	end

	// Lowest matching way wins.
	always_comb begin
		hit_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
		end
		any_hit = |match;
	end

	// Result and row to write back.
	always_comb begin
		row_wr   = row_rd;
		res.hit  = any_hit;
		res.repl = 1'b0;
		res.wb   = 1'b0;
		if (any_hit) begin
			res.way = RES_WAY'(hit_way);
			if (is_write) begin
				row_wr[32'(hit_way)*ENTRY_W + D_BIT] = 1'b1;
			end
		end else begin
			res.way  = RES_WAY'(victim);
			res.repl = valid[victim];
			res.wb   = valid[victim] && dirty[victim];
			row_wr[32'(victim)*ENTRY_W +: ENTRY_W] = {1'b1, 1'b0, tag};
		end
	end

endmodule

### design/set_assoc_cache_tag_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top: set-associative cache tag lookup
// Tag-only cache with random replacement and access statistics.
// ----------------------------------------------------------------------------
// Usage:
//   An access word (req_type, address, victim_pick) enters on in_valid and
//   is taken when in_stall is low. One result word per access leaves on
//   out_valid and is taken when out_stall is low; the counters shown with it
//   are the totals after that access.
//   The set's row is read at the accepting edge into the lookup stage; the
//   compare and write-back act there and the result is registered in the
//   output register. The set's row is written back in the cycle a new
//   access may read it, and the tag memory forwards that row, so the
//   block takes one access per cycle while the output side keeps up.
//   A stalled output holds the finished word; the access behind it waits in
//   the lookup stage and in_stall rises until the output is taken.
//   After reset, and after any write to a defined configuration register,
//   the tag memory is swept clear, one row per cycle, over all rows (MAX_SETS
//   rounded down to a power of two, 1024 by default); in_stall is high
//   throughout. Such writes also clear every counter at once.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top #(
	parameter int MAX_WAYS  = sactl_pkg::DEF_MAX_WAYS,
	parameter int MAX_SETS  = sactl_pkg::DEF_MAX_SETS,
	parameter int ADDR_BITS = sactl_pkg::DEF_ADDR_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sactl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sactl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [ADDR_BITS-1:0]              address,
	input  logic [2:0]                        victim_pick,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [sactl_pkg::WAY_OUT-1:0]     way,
	output logic                              replaced_valid,
	output logic                              writeback,
	output logic [sactl_pkg::CNT_W-1:0]       hit_count,
	output logic [sactl_pkg::CNT_W-1:0]       miss_count,
	output logic [sactl_pkg::CNT_W-1:0]       read_count,
	output logic [sactl_pkg::CNT_W-1:0]       write_count,
	output logic [sactl_pkg::CNT_W-1:0]       writeback_count
);
	import sactl_pkg::*;

	localparam int SET_BITS = $clog2(MAX_SETS + 1) - 1;
	localparam int DEPTH    = 1 << SET_BITS;
	localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WN_W     = $clog2(MAX_WAYS + 1);
	localparam int ROW_W    = MAX_WAYS * (ADDR_BITS + 2);

	// Configuration and clearing sweep.
	logic [CFG_W-1:0] num_ways_q;
	logic [CFG_W-1:0] line_log_q;
	logic [CFG_W-1:0] sets_log_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             cfg_hit;

	// Lookup stage.
	logic                 valid_s1;
	logic [1:0]           type_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic [IDX_W-1:0]     set_s1;
	logic [WAY_W-1:0]     victim_s1;
	logic [MAX_WAYS-1:0]  mask_s1;

	// Output register and counters.
	logic             out_valid_q;
	logic             hit_q;
	logic [WAY_OUT-1:0] way_q;
	logic             repl_q;
	logic             wb_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] reads_q;
	logic [CNT_W-1:0] writes_q;
	logic [CNT_W-1:0] wbs_q;

	// Front-end decode.
	logic                 in_acc;
	logic                 adv;
	logic [ADDR_BITS-1:0] line_num;
	logic [4:0]           eff_sb;
	logic [IDX_W-1:0]     set_mask;
	logic [IDX_W-1:0]     set_idx;
	logic [WN_W-1:0]      ways_eff;
	logic [WAY_W-1:0]     last_way;
	logic [WAY_W-1:0]     victim;
	logic [MAX_WAYS-1:0]  way_mask;

	// Memory and hit logic connections.
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	lkp_res_t         res;

	// Handshake.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy_q || (valid_s1 && !adv);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_hit  = cfg_write && ((cfg_index == REG_NUM_WAYS) ||
		(cfg_index == REG_LINE_LOG) || (cfg_index == REG_SETS_LOG));

	// Line number, set index and saturated configuration.
	always_comb begin
		line_num = address >> line_log_q;
		eff_sb   = (32'(sets_log_q) > SET_BITS) ? 5'(SET_BITS) : 5'(sets_log_q);
		set_mask = IDX_W'((33'd1 << eff_sb) - 33'd1);
		set_idx  = line_num[IDX_W-1:0] & set_mask;
		if (num_ways_q == '0) begin
			ways_eff = WN_W'(1);
		end else if (32'(num_ways_q) > MAX_WAYS) begin
			ways_eff = WN_W'(MAX_WAYS);
		end else begin
			ways_eff = WN_W'(num_ways_q);
		end
		last_way = WAY_W'(ways_eff - WN_W'(1));
		victim   = (32'(victim_pick) > 32'(last_way)) ? last_way : WAY_W'(victim_pick);
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_mask[w] = 32'(ways_eff) > w;
		end
	end

	// Configuration registers and clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ways_q <= RST_NUM_WAYS;
			line_log_q <= RST_LINE_LOG;
			sets_log_q <= RST_SETS_LOG;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_NUM_WAYS: num_ways_q <= cfg_data;
				REG_LINE_LOG: line_log_q <= cfg_data;
				REG_SETS_LOG: sets_log_q <= cfg_data;
				default: ;
			endcase
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_s1   <= req_type;
			tag_s1    <= line_num;
			set_s1    <= set_idx;
			victim_s1 <= victim;
			mask_s1   <= way_mask;
		end
	end

	// Memory write port: sweep rows while clearing, else write back.
	assign ram_we    = clr_busy_q || adv;
	assign ram_waddr = clr_busy_q ? clr_idx_q : set_s1;
	assign ram_wdata = clr_busy_q ? '0 : row_wr;

	sactl_tag_ram #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.ROW_W (ROW_W)
	) u_tag_ram (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (set_idx),
		.rd_data (row_rd),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata)
	);

	sactl_hit_logic #(
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS),
		.WAY_W     (WAY_W)
	) u_hit_logic (
		.row_rd   (row_rd),
		.tag      (tag_s1),
		.way_mask (mask_s1),
		.victim   (victim_s1),
		.is_write (type_s1 == REQ_WRITE),
		.row_wr   (row_wr),
		.res      (res)
	);

	// Counters; a write to a defined configuration register clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			reads_q  <= '0;
			writes_q <= '0;
			wbs_q    <= '0;
		end else if (cfg_hit) begin
			hits_q   <= '0;
			misses_q <= '0;
			reads_q  <= '0;
			writes_q <= '0;
			wbs_q    <= '0;
		end else if (adv) begin
			hits_q   <= hits_q + CNT_W'(res.hit);
			misses_q <= misses_q + CNT_W'(!res.hit);
			reads_q  <= reads_q + CNT_W'(type_s1 == REQ_READ);
			writes_q <= writes_q + CNT_W'(type_s1 == REQ_WRITE);
			wbs_q    <= wbs_q + CNT_W'(res.wb);
		end
	end

	// Output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= res.hit;
			way_q  <= WAY_OUT'(res.way);
			repl_q <= res.repl;
			wb_q   <= res.wb;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign way             = way_q;
	assign replaced_valid  = repl_q;
	assign writeback       = wb_q;
	assign hit_count       = hits_q;
	assign miss_count      = misses_q;
	assign read_count      = reads_q;
	assign write_count     = writes_q;
	assign writeback_count = wbs_q;

endmodule

### design/sactl_checker.sv
// ----------------------------------------------------------------------------
// sactl_checker: port-level checks for the tag lookup
// Watches the top level's ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module sactl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_write,
	input logic [sactl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            in_stall,
	input logic                            hit,
	input logic [sactl_pkg::WAY_OUT-1:0]   way,
	input logic                            replaced_valid,
	input logic                            writeback,
	input logic [sactl_pkg::CNT_W-1:0]     hit_count,
	input logic [sactl_pkg::CNT_W-1:0]     miss_count
);
	import sactl_pkg::*;

	// A hit never evicts anything.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !replaced_valid && !writeback)
		else $error("hit word reports an eviction");

	// A writeback needs a valid victim.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && writeback |-> replaced_valid)
		else $error("writeback without a valid victim");

	// A defined register write starts the clearing sweep and zeroes counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && ((cfg_index == REG_NUM_WAYS) || (cfg_index == REG_LINE_LOG) ||
		(cfg_index == REG_SETS_LOG))
		|=> in_stall && (hit_count == '0) && (miss_count == '0))
		else $error("configuration write did not clear the store");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(way) && $stable(hit))
		else $error("stalled result word changed");

endmodule

bind set_assoc_cache_tag_lookup_top sactl_checker u_sactl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_write      (cfg_write),
	.cfg_index      (cfg_index),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.in_stall       (in_stall),
	.hit            (hit),
	.way            (way),
	.replaced_valid (replaced_valid),
	.writeback      (writeback),
	.hit_count      (hit_count),
	.miss_count     (miss_count)
);
